### design/lps_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lps_pkg
// Shared types, constants and pattern tables of the LED pattern sequencer.
// ---------------------------------------------------------------------------
package lps_pkg;

  localparam int unsigned LED_COUNT     = 8;
  localparam int unsigned SUB_STEP_MS   = 10;
  localparam int unsigned FINAL_HOLD_MS = 1000;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam logic [10:0] INIT_DELAY_RST  = 11'd500;
  localparam logic [8:0]  SPEED_STEP_RST  = 9'd50;
  localparam logic [10:0] DELAY_FLOOR_RST = 11'd50;
  localparam logic [10:0] DELAY_CEIL_RST  = 11'd2000;
  localparam logic [7:0]  GUARD_RST       = 8'd80;
  localparam logic [10:0] LEN_SAT         = 11'd2047;

  // request codes
  typedef enum logic [2:0] {
    REQ_TICK   = 3'd0,
    REQ_FASTER = 3'd1,
    REQ_SLOWER = 3'd2,
    REQ_START  = 3'd3,
    REQ_STOP   = 3'd4,
    REQ_CLEAR  = 3'd5,
    REQ_RSV6   = 3'd6,
    REQ_RSV7   = 3'd7
  } req_t;

  // pattern codes
  localparam logic [2:0] PAT_BOUNCE = 3'd0;
  localparam logic [2:0] PAT_CRASH  = 3'd1;
  localparam logic [2:0] PAT_STACK  = 3'd2;
  localparam logic [2:0] PAT_RACE   = 3'd3;
  localparam logic [2:0] PAT_BINARY = 3'd4;
  localparam logic [2:0] PAT_DANCE  = 3'd5;
  localparam logic [2:0] PAT_FILL   = 3'd6;
  localparam logic [2:0] PAT_STAIR  = 3'd7;

  // configuration register indexes
  localparam logic [2:0] CFG_INIT_DELAY  = 3'd0;
  localparam logic [2:0] CFG_SPEED_STEP  = 3'd1;
  localparam logic [2:0] CFG_DELAY_FLOOR = 3'd2;
  localparam logic [2:0] CFG_DELAY_CEIL  = 3'd3;
  localparam logic [2:0] CFG_GUARD       = 3'd4;

  typedef struct packed {
    logic [2:0] req_type;
    logic [2:0] pattern_select;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  led_frame;
    logic [10:0] delay_now;
    logic        running;
  } out_item_t;

  // classified command passed from front to back
  typedef struct packed {
    logic       tick;
    logic       speed;
    logic       faster;
    logic       start;
    logic       stop;
    logic       clear;
    logic [2:0] pat;
  } cmd_t;

  function automatic logic [7:0] tab_byte(input logic [2:0] p, input logic [7:0] i);
    logic [7:0] b;
    b = 8'h00;
    unique case (p)
      PAT_CRASH: begin
        unique case (i)
          8'd0: b = 8'h81; 8'd1: b = 8'h42; 8'd2: b = 8'h24; 8'd3: b = 8'h18;
          8'd4: b = 8'h18; 8'd5: b = 8'h24; 8'd6: b = 8'h42; 8'd7: b = 8'h81;
          default: b = 8'h00;
        endcase
      end
      PAT_RACE: begin
        unique case (i)
          8'd0: b = 8'h01; 8'd1: b = 8'h02; 8'd2: b = 8'h04; 8'd3: b = 8'h09;
          8'd4: b = 8'h12; 8'd5: b = 8'h14; 8'd6: b = 8'h28; 8'd7: b = 8'h30;
          8'd8: b = 8'h60; 8'd9: b = 8'h40; 8'd10: b = 8'h80;
          default: b = 8'h00;
        endcase
      end
      PAT_DANCE: begin
        unique case (i)
          8'd0: b = 8'hCC; 8'd1: b = 8'h33; 8'd2: b = 8'h3C; 8'd3: b = 8'hC3;
          8'd4: b = 8'hFF; 8'd5: b = 8'hC3; 8'd6: b = 8'h3C; 8'd7: b = 8'h33;
          8'd8: b = 8'hCC;
          default: b = 8'h00;
        endcase
      end
      PAT_STAIR: begin
        unique case (i)
          8'd0: b = 8'h00; 8'd1: b = 8'h81; 8'd2: b = 8'hC3; 8'd3: b = 8'hE7;
          8'd4: b = 8'hFF; 8'd5: b = 8'hE7; 8'd6: b = 8'hC3; 8'd7: b = 8'h81;
          default: b = 8'h00;
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] tab_len(input logic [2:0] p);
    logic [7:0] n;
    unique case (p)
      PAT_CRASH, PAT_STAIR: n = 8'd8;
      PAT_RACE:             n = 8'd11;
      PAT_DANCE:            n = 8'd9;
      default:              n = 8'd0;
    endcase
    return n;
  endfunction

endpackage

### design/lps_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lps_front
// Input side: takes request transactions, decodes them into commands and
// holds them in a short queue for the sequencer core.
// ---------------------------------------------------------------------------
module lps_front #(
  parameter int unsigned DEPTH = lps_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  lps_pkg::in_item_t in_data,
  output logic             cmd_valid,
  input  logic             cmd_take,
  output lps_pkg::cmd_t    cmd
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  lps_pkg::cmd_t        q_r [DEPTH];
  logic [AW-1:0]        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]          cnt_r, cnt_nxt;
  lps_pkg::cmd_t        dec;
  logic                 push_ok, pop_ok;

  // decode request
  always_comb begin
    dec = '0;
    dec.pat = in_data.pattern_select;
    unique case (lps_pkg::req_t'(in_data.req_type))
      lps_pkg::REQ_TICK:   dec.tick = 1'b1;
      lps_pkg::REQ_FASTER: begin dec.speed = 1'b1; dec.faster = 1'b1; end
      lps_pkg::REQ_SLOWER: dec.speed = 1'b1;
      lps_pkg::REQ_START:  dec.start = 1'b1;
      lps_pkg::REQ_STOP:   dec.stop = 1'b1;
      lps_pkg::REQ_CLEAR:  dec.clear = 1'b1;
      default:             dec = dec;
    endcase
  end

  assign in_full   = (cnt_r == AW'(0) + (AW+1)'(DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rp_r];
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = cmd_valid && cmd_take;

  // pointer update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push_ok) wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (pop_ok)  rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    if (push_ok && !pop_ok) cnt_nxt = cnt_r + 1'b1;
    if (!push_ok && pop_ok) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push_ok) q_r[wp_r] <= dec;
  end

endmodule

### design/lps_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lps_core
// Back side: runs commands on the pattern state, one per cycle unless the
// two-entry output queue is full and unpopped, and queues each result frame.
// ---------------------------------------------------------------------------
module lps_core #(
  parameter int unsigned SUB_STEP_MS   = lps_pkg::SUB_STEP_MS,
  parameter int unsigned FINAL_HOLD_MS = lps_pkg::FINAL_HOLD_MS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  output logic              cmd_take,
  input  lps_pkg::cmd_t     cmd,
  input  logic [10:0]       init_delay,
  input  logic [8:0]        speed_step,
  input  logic [10:0]       delay_floor,
  input  logic [10:0]       delay_ceil,
  input  logic [7:0]        guard_ms,
  output logic              out_empty,
  input  logic              out_pop,
  output lps_pkg::out_item_t out_data
);
  localparam logic [10:0] STEP = 11'(SUB_STEP_MS);
  localparam logic [10:0] HOLD = 11'(FINAL_HOLD_MS);
  localparam logic [10:0] LEN_SAT = lps_pkg::LEN_SAT;
  // reciprocal of the sub step, exact for every dividend below 4096
  localparam logic [24:0] RECIP = 25'(((1 << 24) + SUB_STEP_MS - 1) / SUB_STEP_MS);

  // pattern state
  logic [2:0]  pat_r, pat_nxt;
  logic        busy_r, busy_nxt;
  logic [7:0]  fidx_r, fidx_nxt;
  logic        bdown_r, bdown_nxt;
  logic [7:0]  smask_r, smask_nxt;
  logic [3:0]  slvl_r, slvl_nxt;
  logic [1:0]  sph_r, sph_nxt;
  logic [1:0]  blink_r, blink_nxt;
  logic [10:0] cdly_r, cdly_nxt;
  logic [10:0] saved_r [8];
  logic [10:0] ftmr_r, ftmr_nxt;
  logic [10:0] flen_r, flen_nxt;
  logic [7:0]  gtmr_r, gtmr_nxt;
  logic        sv_we, sv_clr;
  logic [2:0]  sv_idx;
  logic [10:0] sv_val;

  // output queue
  lps_pkg::out_item_t oq_r [2];
  logic        ow_r, orp_r;
  logic [1:0]  ocnt_r;
  lps_pkg::out_item_t res;
  logic        do_cmd;

  assign out_empty = (ocnt_r == 2'd0);
  assign out_data  = oq_r[orp_r];
  assign cmd_take  = (ocnt_r != 2'd2) || out_pop;
  assign do_cmd    = cmd_valid && cmd_take;

  // round up to a multiple of the sub step, saturating
  function automatic logic [10:0] wait_len(input logic [10:0] ms);
    logic [11:0] m, q;
    logic [36:0] prod;
    logic [22:0] p;
    m = (ms < STEP) ? {1'b0, STEP} : {1'b0, ms};
    m = m + 12'(STEP) - 12'd1;
    prod = 37'(m) * 37'(RECIP);
    q = prod[35:24];
    p = 23'(q) * 23'(STEP);
    return (p > 23'(LEN_SAT)) ? LEN_SAT : p[10:0];
  endfunction

  function automatic logic [7:0] bit_at(input logic [2:0] i);
    return 8'(1) << i;
  endfunction

  // command execution
  always_comb begin
    logic [2:0]  dpos;
    logic        relen, fin;
    logic [11:0] dsum;
    logic [10:0] sdly;
    pat_nxt = pat_r; busy_nxt = busy_r; fidx_nxt = fidx_r; bdown_nxt = bdown_r;
    smask_nxt = smask_r; slvl_nxt = slvl_r; sph_nxt = sph_r; blink_nxt = blink_r;
    cdly_nxt = cdly_r; ftmr_nxt = ftmr_r; flen_nxt = flen_r; gtmr_nxt = gtmr_r;
    sv_we = 1'b0; sv_clr = 1'b0; sv_idx = pat_r; sv_val = cdly_r;
    relen = 1'b0; fin = 1'b0;
    dpos = 3'd7 - slvl_r[2:0];
    dsum = '0;
    sdly = '0;
    if (do_cmd) begin
      priority if (cmd.tick) begin
        if (gtmr_r != 8'd0) gtmr_nxt = gtmr_r - 8'd1;
        if (busy_r) begin
          ftmr_nxt = (ftmr_r < LEN_SAT) ? ftmr_r + 11'd1 : ftmr_r;
          if (ftmr_nxt >= flen_r) begin
            relen = 1'b1;
            unique case (pat_r)
              lps_pkg::PAT_BOUNCE: begin
                if (!bdown_r) begin
                  if (fidx_r + 8'd1 >= 8'd7) begin fidx_nxt = 8'd7; bdown_nxt = 1'b1; end
                  else fidx_nxt = fidx_r + 8'd1;
                end else begin
                  fidx_nxt = (fidx_r > 8'd0) ? fidx_r - 8'd1 : fidx_r;
                  if (fidx_nxt == 8'd0) bdown_nxt = 1'b0;
                end
              end
              lps_pkg::PAT_STACK: begin
                if (sph_r == 2'd0) begin
                  if (fidx_r < 8'(dpos)) fidx_nxt = fidx_r + 8'd1;
                  else begin sph_nxt = 2'd1; blink_nxt = 2'd0; end
                end else if (sph_r == 2'd1) begin
                  if (blink_r < 2'd3) blink_nxt = blink_r + 2'd1;
                  else begin
                    smask_nxt = smask_r | bit_at(dpos);
                    slvl_nxt  = slvl_r + 4'd1;
                    if (slvl_nxt >= 4'd8) sph_nxt = 2'd2;
                    else begin sph_nxt = 2'd0; fidx_nxt = 8'd0; end
                  end
                end else begin
                  fin = 1'b1; relen = 1'b0;
                end
              end
              lps_pkg::PAT_BINARY: fidx_nxt = fidx_r + 8'd1;
              lps_pkg::PAT_FILL: begin
                if (sph_r == 2'd1) begin sph_nxt = 2'd0; fidx_nxt = 8'd8; end
                else if (fidx_r == 8'd7) begin
                  if (cdly_r == 11'd0) fidx_nxt = 8'd8; else sph_nxt = 2'd1;
                end else fidx_nxt = {4'd0, fidx_r[3:0] + 4'd1};
              end
              default: begin
                fidx_nxt = (fidx_r + 8'd1 >= lps_pkg::tab_len(pat_r)) ? 8'd0
                           : fidx_r + 8'd1;
              end
            endcase
          end
        end
      end else if (cmd.speed) begin
        if (busy_r && !(pat_r == lps_pkg::PAT_STACK && sph_r == 2'd2) &&
            gtmr_r == 8'd0) begin
          gtmr_nxt = guard_ms;
          if (cmd.faster) begin
            dsum = {1'b0, cdly_r} - {3'd0, speed_step};
            cdly_nxt = ({1'b0, cdly_r} < {3'd0, speed_step} + 12'd0 ||
                        dsum < {1'b0, delay_floor}) ? delay_floor : dsum[10:0];
          end else begin
            dsum = {1'b0, cdly_r} + {3'd0, speed_step};
            cdly_nxt = (dsum > {1'b0, delay_ceil}) ? delay_ceil : dsum[10:0];
          end
        end
      end else if (cmd.start) begin
        if (busy_r) begin sv_we = 1'b1; sv_idx = pat_r; sv_val = cdly_r; end
        sdly = (saved_r[cmd.pat] != 11'd0) ? saved_r[cmd.pat] : init_delay;
        // a stop of the same slot saves and is read back in the same step
        if (busy_r && pat_r == cmd.pat) sdly = (cdly_r != 11'd0) ? cdly_r : init_delay;
        pat_nxt = cmd.pat; cdly_nxt = sdly; fidx_nxt = '0; bdown_nxt = 1'b0;
        smask_nxt = '0; slvl_nxt = '0; sph_nxt = '0; blink_nxt = '0;
        busy_nxt = 1'b1; relen = 1'b1;
      end else if (cmd.stop) begin
        if (busy_r) fin = 1'b1;
      end else if (cmd.clear) begin
        sv_clr = 1'b1;
      end
      // new frame length
      if (relen) begin
        ftmr_nxt = '0;
        if (pat_nxt == lps_pkg::PAT_STACK && sph_nxt == 2'd1)
          flen_nxt = wait_len({1'b0, cdly_nxt[10:1]});
        else if (pat_nxt == lps_pkg::PAT_STACK && sph_nxt == 2'd2) begin
          flen_nxt = HOLD;
          if (HOLD == 11'd0) fin = 1'b1;
        end else if (pat_nxt == lps_pkg::PAT_FILL && sph_nxt == 2'd1)
          flen_nxt = cdly_nxt;
        else
          flen_nxt = wait_len(cdly_nxt);
      end
      if (fin) begin
        sv_we = 1'b1; sv_idx = pat_r; sv_val = cdly_nxt; busy_nxt = 1'b0;
      end
    end
  end

  // result frame from next state
  always_comb begin
    logic [2:0] dp;
    logic [7:0] fb;
    dp = 3'd7 - slvl_nxt[2:0];
    fb = 8'd0;
    unique case (pat_nxt)
      lps_pkg::PAT_BOUNCE: fb = bit_at(fidx_nxt[2:0]);
      lps_pkg::PAT_STACK: begin
        if (sph_nxt == 2'd0) fb = smask_nxt | bit_at(fidx_nxt[2:0]);
        else if (sph_nxt == 2'd1) fb = smask_nxt | (blink_nxt[0] ? 8'd0 : bit_at(dp));
        else fb = 8'hFF;
      end
      lps_pkg::PAT_BINARY: fb = fidx_nxt;
      lps_pkg::PAT_FILL: begin
        if (sph_nxt == 2'd1) fb = 8'hFF;
        else if (fidx_nxt < 8'd8) fb = 8'((9'd2 << fidx_nxt[2:0]) - 9'd1);
        else fb = ~8'((9'd2 << fidx_nxt[2:0]) - 9'd1);
      end
      default: fb = lps_pkg::tab_byte(pat_nxt, fidx_nxt);
    endcase
    res.led_frame = busy_nxt ? fb : 8'd0;
    res.delay_now = busy_nxt ? cdly_nxt : 11'd0;
    res.running   = busy_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r <= '0; busy_r <= 1'b0; fidx_r <= '0; bdown_r <= 1'b0; smask_r <= '0;
      slvl_r <= '0; sph_r <= '0; blink_r <= '0; cdly_r <= '0; ftmr_r <= '0;
      flen_r <= '0; gtmr_r <= '0;
      for (int i = 0; i < 8; i++) saved_r[i] <= '0;
      ow_r <= 1'b0; orp_r <= 1'b0; ocnt_r <= '0;
    end else begin
      pat_r <= pat_nxt; busy_r <= busy_nxt; fidx_r <= fidx_nxt; bdown_r <= bdown_nxt;
      smask_r <= smask_nxt; slvl_r <= slvl_nxt; sph_r <= sph_nxt; blink_r <= blink_nxt;
      cdly_r <= cdly_nxt; ftmr_r <= ftmr_nxt; flen_r <= flen_nxt; gtmr_r <= gtmr_nxt;
      if (sv_clr) for (int i = 0; i < 8; i++) saved_r[i] <= '0;
      else if (sv_we) saved_r[sv_idx] <= sv_val;
      if (do_cmd) ow_r <= ~ow_r;
      if (out_pop && !out_empty) orp_r <= ~orp_r;
      ocnt_r <= ocnt_r + {1'b0, do_cmd} - {1'b0, out_pop && !out_empty};
    end
  end

  // output queue storage
  always_ff @(posedge clk) begin
    if (do_cmd) oq_r[ow_r] <= res;
  end

endmodule

### design/led_pattern_sequencer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// led_pattern_sequencer
// Eight-LED pattern generator stepped by millisecond ticks and key requests.
// ---------------------------------------------------------------------------
//  channel | ports                   | moves
//  in      | in_push / in_full       | one request (tick or key)
//  out     | out_pop / out_empty     | one frame result per request
//  cfg     | cfg_valid / cfg_ready   | one register write
//
// One request per cycle sustained while results are popped; a request is
// registered in the decode queue, then its result in the core's output queue.
// Reset is synchronous on rst_n; it clears the pattern state, queue counts and
// saved delays and reloads the register defaults. A full output queue stalls
// the core, which in turn fills the request queue and raises in_full. Configuration writes are always ready.
module led_pattern_sequencer #(
  parameter int unsigned SUB_STEP_MS   = lps_pkg::SUB_STEP_MS,
  parameter int unsigned FINAL_HOLD_MS = lps_pkg::FINAL_HOLD_MS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  lps_pkg::in_item_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output lps_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [10:0]        cfg_wdata
);
  logic [10:0] init_delay_r, floor_r, ceil_r;
  logic [8:0]  step_r;
  logic [7:0]  guard_r;
  logic        cmd_valid, cmd_take;
  lps_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_delay_r <= lps_pkg::INIT_DELAY_RST;
      step_r       <= lps_pkg::SPEED_STEP_RST;
      floor_r      <= lps_pkg::DELAY_FLOOR_RST;
      ceil_r       <= lps_pkg::DELAY_CEIL_RST;
      guard_r      <= lps_pkg::GUARD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lps_pkg::CFG_INIT_DELAY:  init_delay_r <= cfg_wdata;
        lps_pkg::CFG_SPEED_STEP:  step_r       <= cfg_wdata[8:0];
        lps_pkg::CFG_DELAY_FLOOR: floor_r      <= cfg_wdata;
        lps_pkg::CFG_DELAY_CEIL:  ceil_r       <= cfg_wdata;
        lps_pkg::CFG_GUARD:       guard_r      <= cfg_wdata[7:0];
        default:                  guard_r      <= guard_r;
      endcase
    end
  end

  lps_front #(.DEPTH(lps_pkg::QUEUE_DEPTH)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data,
    .cmd_valid, .cmd_take, .cmd
  );

  lps_core #(.SUB_STEP_MS(SUB_STEP_MS), .FINAL_HOLD_MS(FINAL_HOLD_MS)) u_core (
    .clk, .rst_n, .cmd_valid, .cmd_take, .cmd,
    .init_delay(init_delay_r), .speed_step(step_r), .delay_floor(floor_r),
    .delay_ceil(ceil_r), .guard_ms(guard_r),
    .out_empty, .out_pop, .out_data
  );

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LED pattern sequencer. Requests go in through
// the input queue, every frame result is compared field by field with a
// local model. A short stimulus table, a directed stack and fill run, then
// randomised request streams under several register settings.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  lps_pkg::in_item_t in_data = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  lps_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [10:0] cfg_wdata = '0;

  always #1 clk = ~clk;

  led_pattern_sequencer i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // model state
  logic [10:0] m_init_delay, m_floor, m_ceil;
  logic [8:0]  m_step;
  logic [7:0]  m_guard_cfg;
  logic [2:0]  m_pat;
  logic        m_busy, m_bounce_down;
  logic [7:0]  m_index, m_mask;
  logic [3:0]  m_level;
  logic [1:0]  m_phase, m_blink;
  logic [10:0] m_delay, m_timer, m_length;
  logic [10:0] m_saved [8];
  logic [7:0]  m_guard;

  lps_pkg::out_item_t frames_due [$];
  int errors = 0;
  bit hold_off = 1'b0;
  bit gate_sender = 1'b0;
  int idle_cycles = 0;
  int stall_len;

  function automatic logic [10:0] rounded_len(input int ms);
    int n;
    if (ms < lps_pkg::SUB_STEP_MS) ms = lps_pkg::SUB_STEP_MS;
    n = ((ms + lps_pkg::SUB_STEP_MS - 1) / lps_pkg::SUB_STEP_MS) * lps_pkg::SUB_STEP_MS;
    return (n > 2047) ? 11'd2047 : n[10:0];
  endfunction

  function automatic logic [2:0] landing_pos();
    return 3'(7 - m_level);
  endfunction

  function automatic logic [7:0] table_led(input logic [2:0] p, input int i);
    logic [7:0] crash [8] = '{8'h81, 8'h42, 8'h24, 8'h18, 8'h18, 8'h24, 8'h42, 8'h81};
    logic [7:0] race [11] = '{8'h01, 8'h02, 8'h04, 8'h09, 8'h12, 8'h14, 8'h28, 8'h30,
                              8'h60, 8'h40, 8'h80};
    logic [7:0] dance [9] = '{8'hCC, 8'h33, 8'h3C, 8'hC3, 8'hFF, 8'hC3, 8'h3C, 8'h33,
                              8'hCC};
    logic [7:0] stair [8] = '{8'h00, 8'h81, 8'hC3, 8'hE7, 8'hFF, 8'hE7, 8'hC3, 8'h81};
    case (p)
      lps_pkg::PAT_CRASH: return (i < 8) ? crash[i] : 8'h00;
      lps_pkg::PAT_RACE:  return (i < 11) ? race[i] : 8'h00;
      lps_pkg::PAT_DANCE: return (i < 9) ? dance[i] : 8'h00;
      lps_pkg::PAT_STAIR: return (i < 8) ? stair[i] : 8'h00;
      default:            return 8'h00;
    endcase
  endfunction

  function automatic int table_size(input logic [2:0] p);
    case (p)
      lps_pkg::PAT_CRASH, lps_pkg::PAT_STAIR: return 8;
      lps_pkg::PAT_RACE:                      return 11;
      lps_pkg::PAT_DANCE:                     return 9;
      default:                                return 0;
    endcase
  endfunction

  function automatic logic [7:0] leds_now();
    logic [7:0] one_hot;
    if (!m_busy) return 8'h00;
    one_hot = 8'h01 << m_index[2:0];
    case (m_pat)
      lps_pkg::PAT_BOUNCE: return one_hot;
      lps_pkg::PAT_STACK: begin
        if (m_phase == 2'd0) return m_mask | one_hot;
        if (m_phase == 2'd1) return m_mask | (m_blink[0] ? 8'h00 : (8'h01 << landing_pos()));
        return 8'hFF;
      end
      lps_pkg::PAT_BINARY: return m_index;
      lps_pkg::PAT_FILL: begin
        if (m_phase == 2'd1) return 8'hFF;
        if (m_index < 8) return 8'((9'd2 << m_index) - 9'd1);
        return ~8'((9'd2 << m_index[2:0]) - 9'd1);
      end
      default: return table_led(m_pat, m_index);
    endcase
  endfunction

  task automatic load_frame_length();
    if (m_pat == lps_pkg::PAT_STACK && m_phase == 2'd1) m_length = rounded_len(m_delay / 2);
    else if (m_pat == lps_pkg::PAT_STACK && m_phase == 2'd2)
      m_length = 11'(lps_pkg::FINAL_HOLD_MS);
    else if (m_pat == lps_pkg::PAT_FILL && m_phase == 2'd1) m_length = m_delay;
    else m_length = rounded_len(m_delay);
    m_timer = '0;
  endtask

  task automatic stop_pattern();
    m_saved[m_pat] = m_delay;
    m_busy = 1'b0;
  endtask

  task automatic next_frame();
    case (m_pat)
      lps_pkg::PAT_BOUNCE: begin
        if (!m_bounce_down) begin
          m_index++;
          if (m_index >= 7) begin m_index = 7; m_bounce_down = 1'b1; end
        end else begin
          if (m_index > 0) m_index--;
          if (m_index == 0) m_bounce_down = 1'b0;
        end
      end
      lps_pkg::PAT_STACK: begin
        if (m_phase == 2'd0) begin
          if (m_index < landing_pos()) m_index++;
          else begin m_phase = 2'd1; m_blink = '0; end
        end else if (m_phase == 2'd1) begin
          if (m_blink < 3) m_blink++;
          else begin
            m_mask |= 8'h01 << landing_pos();
            m_level++;
            if (m_level >= 8) m_phase = 2'd2;
            else begin m_phase = 2'd0; m_index = '0; end
          end
        end else begin
          stop_pattern();
          return;
        end
      end
      lps_pkg::PAT_BINARY: m_index++;
      lps_pkg::PAT_FILL: begin
        if (m_phase == 2'd1) begin m_phase = 2'd0; m_index = 8; end
        else if (m_index == 7) begin
          if (m_delay == 0) m_index = 8; else m_phase = 2'd1;
        end else m_index = 8'((m_index + 1) & 8'hF);
      end
      default: begin
        m_index++;
        if (m_index >= table_size(m_pat)) m_index = '0;
      end
    endcase
    load_frame_length();
    if (m_pat == lps_pkg::PAT_STACK && m_phase == 2'd2 && m_length == 0) stop_pattern();
  endtask

  task automatic speed_change(input bit faster);
    int d;
    if (!m_busy || (m_pat == lps_pkg::PAT_STACK && m_phase == 2'd2) || m_guard != 0) return;
    m_guard = m_guard_cfg;
    d = m_delay;
    if (faster) begin
      d -= int'(m_step);
      if (d < int'(m_floor)) d = m_floor;
    end else begin
      d += int'(m_step);
      if (d > int'(m_ceil)) d = m_ceil;
    end
    m_delay = d[10:0];
  endtask

  // update the model with one request and queue the frame it produces
  task automatic predict_frame(input lps_pkg::in_item_t it);
    lps_pkg::out_item_t r;
    case (lps_pkg::req_t'(it.req_type))
      lps_pkg::REQ_TICK: begin
        if (m_guard > 0) m_guard--;
        if (m_busy) begin
          if (m_timer < 2047) m_timer++;
          if (m_timer >= m_length) next_frame();
        end
      end
      lps_pkg::REQ_FASTER: speed_change(1'b1);
      lps_pkg::REQ_SLOWER: speed_change(1'b0);
      lps_pkg::REQ_START: begin
        if (m_busy) stop_pattern();
        m_pat = it.pattern_select;
        m_delay = (m_saved[m_pat] != 0) ? m_saved[m_pat] : m_init_delay;
        m_index = '0; m_bounce_down = 1'b0; m_mask = '0; m_level = '0;
        m_phase = '0; m_blink = '0; m_busy = 1'b1;
        load_frame_length();
      end
      lps_pkg::REQ_STOP: if (m_busy) stop_pattern();
      lps_pkg::REQ_CLEAR: foreach (m_saved[k]) m_saved[k] = '0;
      default: ;
    endcase
    r.led_frame = leds_now();
    r.delay_now = m_busy ? m_delay : 11'd0;
    r.running = m_busy;
    frames_due.push_back(r);
  endtask

  task automatic model_reset();
    m_init_delay = lps_pkg::INIT_DELAY_RST; m_step = lps_pkg::SPEED_STEP_RST;
    m_floor = lps_pkg::DELAY_FLOOR_RST;
    m_ceil = lps_pkg::DELAY_CEIL_RST; m_guard_cfg = lps_pkg::GUARD_RST;
    m_pat = '0; m_busy = 0; m_index = '0; m_bounce_down = 0; m_mask = '0;
    m_level = '0; m_phase = '0; m_blink = '0; m_delay = '0; m_timer = '0;
    m_length = '0; m_guard = '0;
    foreach (m_saved[k]) m_saved[k] = '0;
  endtask

  // one request transaction; idle is the gap before it
  task automatic send_request(input lps_pkg::req_t rq, input logic [2:0] pat, input int idle);
    repeat (idle) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= '{req_type: rq, pattern_select: pat};
    do @(posedge clk); while (in_full);
    predict_frame('{req_type: rq, pattern_select: pat});
  endtask

  task automatic release_request();
    in_push <= 1'b0;
  endtask

  task automatic wait_drained();
    release_request();
    while (frames_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // cfg_valid is left high; the caller drops it after the last write
  task automatic write_reg(input logic [2:0] idx, input logic [10:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      lps_pkg::CFG_INIT_DELAY:  m_init_delay = val;
      lps_pkg::CFG_SPEED_STEP:  m_step = val[8:0];
      lps_pkg::CFG_DELAY_FLOOR: m_floor = val;
      lps_pkg::CFG_DELAY_CEIL:  m_ceil = val;
      lps_pkg::CFG_GUARD:       m_guard_cfg = val[7:0];
      default: ;
    endcase
  endtask

  task automatic write_setting(input int a, input int b, input int c, input int d,
                               input int e);
    write_reg(lps_pkg::CFG_INIT_DELAY, a[10:0]);
    write_reg(lps_pkg::CFG_SPEED_STEP, b[10:0]);
    write_reg(lps_pkg::CFG_DELAY_FLOOR, c[10:0]);
    write_reg(lps_pkg::CFG_DELAY_CEIL, d[10:0]);
    write_reg(lps_pkg::CFG_GUARD, e[10:0]);
    cfg_valid <= 1'b0;
  endtask

  // random sender: bursts of mostly ticks with keys mixed in
  task automatic random_stream(input int count, input int max_idle);
    int burst;
    int n;
    int sel;
    lps_pkg::req_t rq;
    n = 0;
    while (n < count) begin
      burst = $urandom_range(1, 30);
      for (int b = 0; b < burst && n < count; b++) begin
        sel = $urandom_range(0, 99);
        if (sel < 70) rq = lps_pkg::REQ_TICK;
        else if (sel < 78) rq = lps_pkg::REQ_FASTER;
        else if (sel < 86) rq = lps_pkg::REQ_SLOWER;
        else if (sel < 92) rq = lps_pkg::REQ_START;
        else if (sel < 95) rq = lps_pkg::REQ_STOP;
        else if (sel < 97) rq = lps_pkg::REQ_CLEAR;
        else rq = lps_pkg::req_t'($urandom_range(6, 7));
        send_request(rq, 3'($urandom_range(0, 7)), (b == 0) ? $urandom_range(0, max_idle) : 0);
        n++;
      end
    end
  endtask

  // receiver: own stall pattern, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_pop <= 1'b0;
        repeat (stall_len) @(posedge clk);
        hold_off = 1'b0;
      end
      out_pop <= ($urandom_range(0, 3) != 0) || gate_sender;
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty) || cfg_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
      if (out_pop && !out_empty) begin
        if (frames_due.size() == 0) begin
          $error("unexpected frame %h", out_data);
          errors++;
        end else begin
          lps_pkg::out_item_t e;
          e = frames_due.pop_front();
          if (out_data.led_frame !== e.led_frame) begin
            $error("led_frame exp %h got %h", e.led_frame, out_data.led_frame); errors++;
          end
          if (out_data.delay_now !== e.delay_now) begin
            $error("delay_now exp %0d got %0d", e.delay_now, out_data.delay_now); errors++;
          end
          if (out_data.running !== e.running) begin
            $error("running exp %b got %b", e.running, out_data.running); errors++;
          end
        end
      end
    end
  end

  typedef struct {
    lps_pkg::req_t rq;
    logic [2:0] pat;
    bit known;
    lps_pkg::out_item_t frame;
  } step_row_t;

  step_row_t plan [] = '{
    '{lps_pkg::REQ_TICK,   lps_pkg::PAT_BOUNCE, 1, '{8'h00, 11'd0, 1'b0}},
    '{lps_pkg::REQ_FASTER, lps_pkg::PAT_BOUNCE, 1, '{8'h00, 11'd0, 1'b0}},
    '{lps_pkg::REQ_STOP,   lps_pkg::PAT_BOUNCE, 1, '{8'h00, 11'd0, 1'b0}},
    '{lps_pkg::REQ_RSV7,   lps_pkg::PAT_STAIR,  1, '{8'h00, 11'd0, 1'b0}},
    '{lps_pkg::REQ_START,  lps_pkg::PAT_BOUNCE, 1, '{8'h01, 11'd500, 1'b1}},
    '{lps_pkg::REQ_FASTER, lps_pkg::PAT_BOUNCE, 1, '{8'h01, 11'd450, 1'b1}},
    '{lps_pkg::REQ_SLOWER, lps_pkg::PAT_BOUNCE, 1, '{8'h01, 11'd450, 1'b1}},
    '{lps_pkg::REQ_START,  lps_pkg::PAT_CRASH,  1, '{8'h81, 11'd500, 1'b1}},
    '{lps_pkg::REQ_START,  lps_pkg::PAT_BOUNCE, 1, '{8'h01, 11'd450, 1'b1}},
    '{lps_pkg::REQ_CLEAR,  lps_pkg::PAT_BOUNCE, 1, '{8'h01, 11'd450, 1'b1}},
    '{lps_pkg::REQ_START,  lps_pkg::PAT_STACK,  1, '{8'h01, 11'd500, 1'b1}},
    '{lps_pkg::REQ_START,  lps_pkg::PAT_RACE,   1, '{8'h01, 11'd500, 1'b1}},
    '{lps_pkg::REQ_START,  lps_pkg::PAT_BINARY, 1, '{8'h00, 11'd500, 1'b1}},
    '{lps_pkg::REQ_START,  lps_pkg::PAT_DANCE,  1, '{8'hCC, 11'd500, 1'b1}},
    '{lps_pkg::REQ_START,  lps_pkg::PAT_FILL,   1, '{8'h01, 11'd500, 1'b1}},
    '{lps_pkg::REQ_START,  lps_pkg::PAT_STAIR,  1, '{8'h00, 11'd500, 1'b1}},
    '{lps_pkg::REQ_TICK,   lps_pkg::PAT_STAIR,  0, '{8'h00, 11'd0, 1'b0}},
    '{lps_pkg::REQ_RSV6,   lps_pkg::PAT_FILL,   0, '{8'h00, 11'd0, 1'b0}},
    '{lps_pkg::REQ_STOP,   lps_pkg::PAT_STAIR,  1, '{8'h00, 11'd0, 1'b0}}
  };

  initial begin
    model_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // table walk: fixed frames also checked against the model
    foreach (plan[k]) begin
      send_request(plan[k].rq, plan[k].pat, $urandom_range(0, 2));
      if (plan[k].known && frames_due[$] !== plan[k].frame) begin
        $error("row %0d frame exp %h model %h", k, plan[k].frame, frames_due[$]);
        errors++;
      end
    end
    wait_drained();

    // short delays and no guard: early stack landings, then a full fill-empty
    write_setting(10, 1, 10, 2000, 0);
    send_request(lps_pkg::REQ_START, lps_pkg::PAT_STACK, 0);
    repeat (200) send_request(lps_pkg::REQ_TICK, lps_pkg::PAT_BOUNCE, 0);
    send_request(lps_pkg::REQ_START, lps_pkg::PAT_FILL, 0);
    repeat (170) send_request(lps_pkg::REQ_TICK, lps_pkg::PAT_BOUNCE, 0);
    wait_drained();

    // receiver holds off while the sender keeps pushing
    stall_len = 300;
    hold_off = 1'b1;
    random_stream(30, 0);
    wait_drained();

    // extremes of the registers
    write_setting(2000, 500, 2000, 10, 255);
    random_stream(30, 6);
    gate_sender = 1'b1;
    wait_drained();
    gate_sender = 1'b0;
    write_setting(10, 500, 10, 2000, 1);
    random_stream(40, 4);
    wait_drained();
    write_setting(0, 511, 0, 2047, 0);
    random_stream(30, 3);
    wait_drained();
    write_setting(500, 50, 50, 2000, 80);
    random_stream(30, 5);
    wait_drained();

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
